[design/box_corner_transform_bounds_macros.svh]
// Assertion macros shared by the box corner transform bounds RTL.
`ifndef BOX_CORNER_TRANSFORM_BOUNDS_MACROS_SVH
`define BOX_CORNER_TRANSFORM_BOUNDS_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bct_pkg.sv]
// Shared types, codes and helpers for the box corner transform bounds block.
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int LANES  = 3;
   localparam int COLS   = 4;
   localparam int ROWS   = 4;
   localparam int ROW_W  = 2;
   localparam int SLOT_W = 3;

   // Input opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CORNER = 2'd1;
   localparam logic [1:0] OP_ORIGIN = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_CORNER = 3'd0;
   localparam logic [2:0] KIND_MIN    = 3'd1;
   localparam logic [2:0] KIND_MAX    = 3'd2;
   localparam logic [2:0] KIND_ORIGIN = 3'd3;
   localparam logic [2:0] KIND_ROW    = 3'd4;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [ROW_W-1:0]      row_index;
      logic signed [31:0]    value_a;
      logic signed [31:0]    value_b;
      logic signed [31:0]    value_c;
      logic signed [31:0]    value_d;
      logic signed [31:0]    value_e;
      logic signed [31:0]    value_f;
      logic                  final_corner;
   } req_type;

   typedef struct packed {
      logic [2:0]            kind;
      logic [ROW_W-1:0]      out_row;
      logic signed [31:0]    out_a;
      logic signed [31:0]    out_b;
      logic signed [31:0]    out_c;
      logic signed [31:0]    out_d;
      logic                  run_end;
   } rsp_type;

   // Control that rides along with one result slot down the pipeline
   typedef struct packed {
      logic             valid;
      logic [2:0]       kind;
      logic [ROW_W-1:0] row;
      logic             last;
   } ctl_type;

   // Largest value of the saturation range (value width capped at the port width)
   function automatic longint sat_max(input int value_width);
      int sw;
      sw = (value_width > DATA_WIDTH) ? DATA_WIDTH : value_width;
      return (longint'(1) << (sw - 1)) - longint'(1);
   endfunction

endpackage

`default_nettype wire

[design/bct_seq.sv]
// Input register, transform matrix store and result slot sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "box_corner_transform_bounds_macros.svh"

module bct_seq #(
   parameter int FRAC_BITS = bct_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bct_pkg::req_type  req_data,
   output bct_pkg::ctl_type       issue_ctl,
   output bct_pkg::data_type      coef [bct_pkg::LANES][bct_pkg::COLS],
   output bct_pkg::data_type      xval [bct_pkg::LANES][bct_pkg::LANES]
);

   localparam bct_pkg::data_type UNIT = bct_pkg::data_type'(longint'(1) << FRAC_BITS);

   bct_pkg::req_type          item_ff;
   logic                      item_valid_ff;
   logic                      item_valid_in;
   logic [bct_pkg::SLOT_W-1:0] slot_ff;
   logic [bct_pkg::SLOT_W-1:0] slot_in;
   logic [bct_pkg::SLOT_W-1:0] slot_count;
   logic                      last_slot;
   logic                      take;
   logic                      row_slot;
   logic [bct_pkg::ROW_W-1:0] row_r;
   bct_pkg::data_type         matrix_ff [bct_pkg::ROWS][bct_pkg::COLS];

   // Count the result slots the held item occupies
   always_comb begin
      case (item_ff.opcode)
         bct_pkg::OP_CORNER: slot_count = item_ff.final_corner ? 3'd3 : 3'd1;
         bct_pkg::OP_ORIGIN: slot_count = 3'd5;
         default:            slot_count = 3'd1;
      endcase
   end

   assign last_slot = (slot_ff == slot_count - 3'd1);
   assign take      = adv && (!item_valid_ff || last_slot);
   assign req_stall = !take;

   assign item_valid_in = take ? req_valid : item_valid_ff;
   assign slot_in       = (adv && item_valid_ff) ? (last_slot ? '0 : slot_ff + 3'd1) : slot_ff;

   // Decode the slot being issued this cycle
   assign row_slot = item_valid_ff && (item_ff.opcode == bct_pkg::OP_ORIGIN) && (slot_ff != '0);
   assign row_r    = bct_pkg::ROW_W'(slot_ff - 3'd1);

   always_comb begin
      issue_ctl = '0;
      if (item_valid_ff) begin
         case (item_ff.opcode)
            bct_pkg::OP_CORNER: begin
               issue_ctl.valid = 1'b1;
               issue_ctl.last  = last_slot;
               if (slot_ff == 3'd0) begin
                  issue_ctl.kind = bct_pkg::KIND_CORNER;
               end else if (slot_ff == 3'd1) begin
                  issue_ctl.kind = bct_pkg::KIND_MIN;
               end else begin
                  issue_ctl.kind = bct_pkg::KIND_MAX;
               end
            end
            bct_pkg::OP_ORIGIN: begin
               issue_ctl.valid = 1'b1;
               issue_ctl.last  = last_slot;
               if (slot_ff == 3'd0) begin
                  issue_ctl.kind = bct_pkg::KIND_ORIGIN;
               end else begin
                  issue_ctl.kind = bct_pkg::KIND_ROW;
                  issue_ctl.row  = row_r;
               end
            end
            default: issue_ctl = '0;
         endcase
      end
   end

   // Route matrix rows and operands to the three multiplier lanes
   always_comb begin
      for (int c = 0; c < bct_pkg::COLS; c++) begin
         coef[0][c] = row_slot ? matrix_ff[row_r][c] : matrix_ff[0][c];
         coef[1][c] = row_slot ? matrix_ff[row_r][c] : matrix_ff[1][c];
         coef[2][c] = matrix_ff[2][c];
      end
      for (int l = 0; l < bct_pkg::LANES; l++) begin
         xval[l][0] = item_ff.value_a;
         xval[l][1] = item_ff.value_b;
         xval[l][2] = item_ff.value_c;
      end
      if (row_slot) begin
         xval[1][0] = item_ff.value_d;
         xval[1][1] = item_ff.value_e;
         xval[1][2] = item_ff.value_f;
      end
   end

   // Hold the item and advance the slot counter; load matrix rows
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         slot_ff       <= '0;
         for (int r = 0; r < bct_pkg::ROWS; r++) begin
            for (int c = 0; c < bct_pkg::COLS; c++) begin
               matrix_ff[r][c] <= (r == c) ? UNIT : '0;
            end
         end
      end else begin
         item_valid_ff <= item_valid_in;
         slot_ff       <= slot_in;
         if (adv && item_valid_ff && (item_ff.opcode == bct_pkg::OP_LOAD)) begin
            matrix_ff[item_ff.row_index][0] <= item_ff.value_a;
            matrix_ff[item_ff.row_index][1] <= item_ff.value_b;
            matrix_ff[item_ff.row_index][2] <= item_ff.value_c;
            matrix_ff[item_ff.row_index][3] <= item_ff.value_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         item_ff <= req_data;
      end
   end

   `BCT_ASSERT_NOW(a_slot_in_range, item_valid_ff, slot_ff < slot_count, "slot counter past item result count")
   `BCT_ASSERT_NOW(a_take_on_last, adv && issue_ctl.valid && issue_ctl.last, !req_stall, "last slot issued but next item refused")

endmodule

`default_nettype wire

[design/bct_mac.sv]
// Multiply stage and scale, saturate and sum stage for three lanes.
`timescale 1ns / 1ps
`default_nettype none
`include "box_corner_transform_bounds_macros.svh"

module bct_mac #(
   parameter int VALUE_WIDTH = bct_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = bct_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire bct_pkg::ctl_type  issue_ctl,
   input  wire bct_pkg::data_type coef [bct_pkg::LANES][bct_pkg::COLS],
   input  wire bct_pkg::data_type xval [bct_pkg::LANES][bct_pkg::LANES],
   output bct_pkg::ctl_type       sum_ctl,
   output bct_pkg::data_type      sum_res [bct_pkg::COLS]
);

   localparam int     DW     = bct_pkg::DATA_WIDTH;
   localparam longint SAT_HI = bct_pkg::sat_max(VALUE_WIDTH);
   localparam longint SAT_LO = -SAT_HI - longint'(1);

   bct_pkg::ctl_type  ctl1_ff;
   bct_pkg::ctl_type  ctl2_ff;
   bct_pkg::prod_type prod_ff   [bct_pkg::LANES][bct_pkg::LANES];
   bct_pkg::data_type addend_ff [bct_pkg::LANES];
   bct_pkg::data_type scaled    [bct_pkg::LANES][bct_pkg::LANES];
   bct_pkg::data_type lane_sum  [bct_pkg::LANES];
   bct_pkg::data_type res_in    [bct_pkg::COLS];
   bct_pkg::data_type res_ff    [bct_pkg::COLS];

   // Drop the fraction bits (floor) and clamp to the value range
   function automatic bct_pkg::data_type scale_sat(input bct_pkg::prod_type p);
      bct_pkg::prod_type q;
      q = p >>> FRAC_BITS;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return DW'(q);
   endfunction

   function automatic bct_pkg::data_type add_sat(input bct_pkg::data_type a,
                                                 input bct_pkg::data_type b);
      bct_pkg::prod_type s;
      s = bct_pkg::prod_type'(a) + bct_pkg::prod_type'(b);
      if (s > SAT_HI) begin
         s = SAT_HI;
      end else if (s < SAT_LO) begin
         s = SAT_LO;
      end
      return DW'(s);
   endfunction

   // Register the nine products and the row offsets
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < bct_pkg::LANES; l++) begin
            for (int j = 0; j < bct_pkg::LANES; j++) begin
               prod_ff[l][j] <= bct_pkg::prod_type'(coef[l][j]) *
                                bct_pkg::prod_type'(xval[l][j]);
            end
            addend_ff[l] <= coef[l][bct_pkg::COLS-1];
         end
      end
   end

   // Scale each product and sum each lane in model order
   always_comb begin
      for (int l = 0; l < bct_pkg::LANES; l++) begin
         for (int j = 0; j < bct_pkg::LANES; j++) begin
            scaled[l][j] = scale_sat(prod_ff[l][j]);
         end
         lane_sum[l] = add_sat(add_sat(add_sat(scaled[l][0], scaled[l][1]), scaled[l][2]),
                               addend_ff[l]);
      end
      if (ctl1_ff.kind == bct_pkg::KIND_ROW) begin
         res_in[0] = scaled[1][0];
         res_in[1] = scaled[1][1];
         res_in[2] = scaled[1][2];
         res_in[3] = lane_sum[0];
      end else begin
         res_in[0] = lane_sum[0];
         res_in[1] = lane_sum[1];
         res_in[2] = lane_sum[2];
         res_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   // Advance slot control alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= issue_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   assign sum_ctl = ctl2_ff;
   assign sum_res = res_ff;

   `BCT_ASSERT_NOW(a_min_then_max, ctl2_ff.valid && ctl2_ff.kind == bct_pkg::KIND_MIN, ctl1_ff.valid && ctl1_ff.kind == bct_pkg::KIND_MAX, "bounds max slot does not follow min slot")
   `BCT_ASSERT_NOW(a_final_corner_then_min, ctl2_ff.valid && ctl2_ff.kind == bct_pkg::KIND_CORNER && !ctl2_ff.last, ctl1_ff.valid && ctl1_ff.kind == bct_pkg::KIND_MIN, "final corner not followed by bounds min")

endmodule

`default_nettype wire

[design/bct_out.sv]
// Bounds accumulators and the result output register.
`timescale 1ns / 1ps
`default_nettype none
`include "box_corner_transform_bounds_macros.svh"

module bct_out #(
   parameter int VALUE_WIDTH = bct_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire bct_pkg::ctl_type  sum_ctl,
   input  wire bct_pkg::data_type sum_res [bct_pkg::COLS],
   output logic                   rsp_valid,
   output bct_pkg::rsp_type       rsp_data
);

   localparam longint            SAT_MAX = bct_pkg::sat_max(VALUE_WIDTH);
   localparam bct_pkg::data_type SAT_HI  = bct_pkg::data_type'(SAT_MAX);
   localparam bct_pkg::data_type SAT_LO  = bct_pkg::data_type'(-SAT_MAX - longint'(1));

   logic              rsp_valid_ff;
   bct_pkg::rsp_type  rsp_ff;
   bct_pkg::rsp_type  rsp_in;
   bct_pkg::data_type bmin_ff [bct_pkg::LANES];
   bct_pkg::data_type bmax_ff [bct_pkg::LANES];
   logic              take_corner;
   logic              take_max;

   assign take_corner = adv && sum_ctl.valid && (sum_ctl.kind == bct_pkg::KIND_CORNER);
   assign take_max    = adv && sum_ctl.valid && (sum_ctl.kind == bct_pkg::KIND_MAX);

   // Pick the item payload by kind
   always_comb begin
      rsp_in.kind    = sum_ctl.kind;
      rsp_in.out_row = sum_ctl.row;
      rsp_in.run_end = sum_ctl.last;
      rsp_in.out_d   = sum_res[3];
      case (sum_ctl.kind)
         bct_pkg::KIND_MIN: begin
            rsp_in.out_a = bmin_ff[0];
            rsp_in.out_b = bmin_ff[1];
            rsp_in.out_c = bmin_ff[2];
         end
         bct_pkg::KIND_MAX: begin
            rsp_in.out_a = bmax_ff[0];
            rsp_in.out_b = bmax_ff[1];
            rsp_in.out_c = bmax_ff[2];
         end
         default: begin
            rsp_in.out_a = sum_res[0];
            rsp_in.out_b = sum_res[1];
            rsp_in.out_c = sum_res[2];
         end
      endcase
   end

   // Track per-axis extremes; clear them once the max item leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bct_pkg::LANES; i++) begin
            bmin_ff[i] <= SAT_HI;
            bmax_ff[i] <= SAT_LO;
         end
      end else begin
         if (adv) begin
            rsp_valid_ff <= sum_ctl.valid;
         end
         for (int i = 0; i < bct_pkg::LANES; i++) begin
            if (take_max) begin
               bmin_ff[i] <= SAT_HI;
               bmax_ff[i] <= SAT_LO;
            end else if (take_corner) begin
               if (sum_res[i] < bmin_ff[i]) begin
                  bmin_ff[i] <= sum_res[i];
               end
               if (sum_res[i] > bmax_ff[i]) begin
                  bmax_ff[i] <= sum_res[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BCT_ASSERT_NEXT(a_bounds_cleared, take_max, bmin_ff[0] == SAT_HI && bmax_ff[0] == SAT_LO && bmin_ff[2] == SAT_HI, "bounds not cleared after max item")

endmodule

`default_nettype wire

[design/box_corner_transform_bounds.sv]
// Top level: transforms box corners by a 4x4 fixed-point matrix and tracks bounds.
// The first result of an item reaches rsp through the product, sum and output registers
//   that lie behind the input register.
// The sequencer issues one slot per cycle while rsp is not stalled; a matrix row or plain
//   corner occupies one slot, a final corner three, an origin-and-extents item five.
// Reset (synchronous): matrix to identity, bounds to the range extremes, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module box_corner_transform_bounds #(
   parameter int VALUE_WIDTH = bct_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = bct_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bct_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bct_pkg::rsp_type       rsp_data
);

   logic              adv;
   bct_pkg::ctl_type  issue_ctl;
   bct_pkg::ctl_type  sum_ctl;
   bct_pkg::data_type coef    [bct_pkg::LANES][bct_pkg::COLS];
   bct_pkg::data_type xval    [bct_pkg::LANES][bct_pkg::LANES];
   bct_pkg::data_type sum_res [bct_pkg::COLS];

   // Advance the whole pipeline whenever the output register can take an item
   assign adv = !rsp_valid || !rsp_stall;

   bct_seq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .issue_ctl (issue_ctl),
      .coef      (coef),
      .xval      (xval)
   );

   bct_mac #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .issue_ctl (issue_ctl),
      .coef      (coef),
      .xval      (xval),
      .sum_ctl   (sum_ctl),
      .sum_res   (sum_res)
   );

   bct_out #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .sum_ctl   (sum_ctl),
      .sum_res   (sum_res),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for box_corner_transform_bounds: directed and random items checked against a predictor.
`timescale 1ns / 1ps

// Predicts corner, bounds and composed-matrix results and checks them in order
class xform_scoreboard;
   localparam int FRAC = bct_pkg::FRAC_BITS_DEF;
   localparam longint VAL_MAX = 64'sh7FFF_FFFF;
   localparam longint VAL_MIN = -64'sh8000_0000;

   longint matrix [16];
   longint axis_lo [3];
   longint axis_hi [3];
   bct_pkg::rsp_type expected_results [$];
   int mismatches;

   function new();
      for (int i = 0; i < 16; i++) begin
         matrix[i] = (i % 5 == 0) ? (longint'(1) <<< FRAC) : 0;
      end
      clear_bounds();
      mismatches = 0;
   endfunction

   function void clear_bounds();
      for (int i = 0; i < 3; i++) begin
         axis_lo[i] = VAL_MAX;
         axis_hi[i] = VAL_MIN;
      end
   endfunction

   function longint clamp(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   // Floor of the exact product over 2^FRAC, then saturate
   function longint fixed_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> FRAC);
   endfunction

   function longint transform_axis(int r, longint x, longint y, longint z);
      longint s;
      s = fixed_mul(matrix[r*4], x);
      s = clamp(s + fixed_mul(matrix[r*4+1], y));
      s = clamp(s + fixed_mul(matrix[r*4+2], z));
      return clamp(s + matrix[r*4+3]);
   endfunction

   function void push(logic [2:0] kind, logic [1:0] row, longint a, longint b, longint c,
                      longint d, logic last);
      bct_pkg::rsp_type res;
      res.kind    = kind;
      res.out_row = row;
      res.out_a   = 32'(a);
      res.out_b   = 32'(b);
      res.out_c   = 32'(c);
      res.out_d   = 32'(d);
      res.run_end = last;
      expected_results.push_back(res);
   endfunction

   // Advance the predicted state by one accepted item
   function void note_item(bct_pkg::req_type it);
      longint v [6];
      longint p [4];
      v[0] = longint'($signed(it.value_a));
      v[1] = longint'($signed(it.value_b));
      v[2] = longint'($signed(it.value_c));
      v[3] = longint'($signed(it.value_d));
      v[4] = longint'($signed(it.value_e));
      v[5] = longint'($signed(it.value_f));
      case (it.opcode)
         bct_pkg::OP_LOAD: begin
            for (int j = 0; j < 4; j++) matrix[it.row_index*4 + j] = v[j];
         end
         bct_pkg::OP_CORNER: begin
            for (int i = 0; i < 3; i++) begin
               p[i] = transform_axis(i, v[0], v[1], v[2]);
               if (p[i] < axis_lo[i]) axis_lo[i] = p[i];
               if (p[i] > axis_hi[i]) axis_hi[i] = p[i];
            end
            push(bct_pkg::KIND_CORNER, 0, p[0], p[1], p[2], 0, !it.final_corner);
            if (it.final_corner) begin
               push(bct_pkg::KIND_MIN, 0, axis_lo[0], axis_lo[1], axis_lo[2], 0, 1'b0);
               push(bct_pkg::KIND_MAX, 0, axis_hi[0], axis_hi[1], axis_hi[2], 0, 1'b1);
               clear_bounds();
            end
         end
         bct_pkg::OP_ORIGIN: begin
            for (int i = 0; i < 4; i++) p[i] = transform_axis(i, v[0], v[1], v[2]);
            push(bct_pkg::KIND_ORIGIN, 0, p[0], p[1], p[2], 0, 1'b0);
            for (int i = 0; i < 4; i++) begin
               push(bct_pkg::KIND_ROW, 2'(i), fixed_mul(matrix[i*4], v[3]),
                    fixed_mul(matrix[i*4+1], v[4]), fixed_mul(matrix[i*4+2], v[5]),
                    p[i], i == 3);
            end
         end
         default: ;
      endcase
   endfunction

   function void report(string what, bct_pkg::rsp_type e, bct_pkg::rsp_type g);
      if (mismatches < 10) begin
         $display("mismatch (%s) at %0t", what, $realtime);
         $display("  expected kind %0d row %0d a %h b %h c %h d %h end %0d",
                  e.kind, e.out_row, e.out_a, e.out_b, e.out_c, e.out_d, e.run_end);
         $display("  actual   kind %0d row %0d a %h b %h c %h d %h end %0d",
                  g.kind, g.out_row, g.out_a, g.out_b, g.out_c, g.out_d, g.run_end);
      end
      mismatches++;
   endfunction

   // Compare one accepted result with the oldest expectation
   function void check_result(bct_pkg::rsp_type got);
      bct_pkg::rsp_type exp;
      if (expected_results.size() == 0) begin
         report("no result expected", '0, got);
         return;
      end
      exp = expected_results.pop_front();
      if (got.kind !== exp.kind || got.out_row !== exp.out_row ||
          got.out_a !== exp.out_a || got.out_b !== exp.out_b ||
          got.out_c !== exp.out_c || got.out_d !== exp.out_d ||
          got.run_end !== exp.run_end) begin
         report("field differs", exp, got);
      end
   endfunction

   function int pending();
      return expected_results.size();
   endfunction
endclass

module tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 90;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             rsp_stall = 1'b0;
   bct_pkg::req_type req_data = '0;
   logic             req_stall;
   logic             rsp_valid;
   bct_pkg::rsp_type rsp_data;

   bit          idle_on = 1'b1;
   int unsigned cycles = 0;
   xform_scoreboard board;

   box_corner_transform_bounds dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   always #6 clock = ~clock;

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 19);
   end

   // Note accepted items and check accepted results
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_item(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL box_corner_transform_bounds");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return int'($urandom_range(16 * 65536)) - 8 * 65536;
      if (pick < 80) return $urandom;
      case ($urandom_range(4))
         0: return MAXV;
         1: return MINV;
         2: return 32'sd0;
         3: return ONE;
         default: return -ONE;
      endcase
   endfunction

   function automatic bct_pkg::req_type make_item(logic [1:0] op, logic [1:0] row,
                                                  logic fin,
                                                  logic signed [31:0] a, logic signed [31:0] b,
                                                  logic signed [31:0] c, logic signed [31:0] d,
                                                  logic signed [31:0] e, logic signed [31:0] f);
      bct_pkg::req_type it;
      it.opcode       = op;
      it.row_index    = row;
      it.final_corner = fin;
      it.value_a      = a;
      it.value_b      = b;
      it.value_c      = c;
      it.value_d      = d;
      it.value_e      = e;
      it.value_f      = f;
      return it;
   endfunction

   function automatic bct_pkg::req_type rand_item(logic [1:0] op, logic fin);
      return make_item(op, 2'($urandom_range(3)), fin, rand_value(), rand_value(),
                       rand_value(), rand_value(), rand_value(), rand_value());
   endfunction

   // Present one item after an optional gap and hold it until accepted
   task automatic send_item(bct_pkg::req_type it);
      while (idle_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   initial begin
      int sent;
      int pick;
      int n;
      board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Corners through the identity matrix, extremes, single-corner box
      send_item(make_item(bct_pkg::OP_CORNER, 2'd0, 1'b0, ONE, 2 * ONE, -3 * ONE, MAXV, MINV,
                          0));
      send_item(make_item(bct_pkg::OP_CORNER, 2'd3, 1'b1, MAXV, MINV, 0, MINV, MAXV, -1));
      send_item(make_item(bct_pkg::OP_CORNER, 2'd1, 1'b1, -1, 1, MINV, 0, 0, 0));
      // Unused opcode is dropped
      send_item(rand_item(OP_UNUSED, 1'b0));
      send_item(make_item(bct_pkg::OP_ORIGIN, 2'd2, 1'b0, ONE, -ONE, MAXV, 2 * ONE, MINV,
                          MAXV));
      // Load every row, some with extremes; final flag on a load is ignored
      send_item(make_item(bct_pkg::OP_LOAD, 2'd0, 1'b1, MAXV, MINV, ONE, MINV, MAXV, MINV));
      send_item(make_item(bct_pkg::OP_LOAD, 2'd1, 1'b0, MINV, MINV, MINV, MAXV, 0, 0));
      send_item(make_item(bct_pkg::OP_LOAD, 2'd2, 1'b0, 0, ONE / 2, -ONE, 3 * ONE, -1, -1));
      send_item(make_item(bct_pkg::OP_LOAD, 2'd3, 1'b0, ONE, ONE, ONE, ONE, 0, 0));
      // Saturate both ways, then round a negative product toward minus infinity
      send_item(make_item(bct_pkg::OP_CORNER, 2'd0, 1'b0, MAXV, MAXV, MAXV, 0, 0, 0));
      send_item(make_item(bct_pkg::OP_CORNER, 2'd2, 1'b0, MINV, MINV, MINV, 0, 0, 0));
      send_item(make_item(bct_pkg::OP_CORNER, 2'd0, 1'b1, -1, -1, -1, MAXV, MAXV, MAXV));
      // Final flag on an origin item is ignored
      send_item(make_item(bct_pkg::OP_ORIGIN, 2'd1, 1'b1, MINV, MAXV, -ONE, MAXV, MINV, -1));
      send_item(rand_item(OP_UNUSED, 1'b1));
      send_item(make_item(bct_pkg::OP_ORIGIN, 2'd0, 1'b0, 0, 0, 0, 0, 0, 0));
      drain_results();

      // Mostly well-formed boxes and origin items with random matrices
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_on = !(sent >= 40 && sent < 70);
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_item(rand_item(bct_pkg::OP_LOAD, 1'($urandom_range(1))));
            sent++;
         end else if (pick < 62) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) send_item(rand_item(bct_pkg::OP_CORNER, k == n - 1));
            sent += n;
         end else if (pick < 85) begin
            send_item(rand_item(bct_pkg::OP_ORIGIN, 1'($urandom_range(1))));
            sent++;
         end else if (pick < 94) begin
            send_item(rand_item(OP_UNUSED, 1'($urandom_range(1))));
         end else begin
            drain_results();
         end
      end
      idle_on = 1'b1;

      // Wait out the last results and the pipeline depth
      drain_results();
      repeat (16) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS box_corner_transform_bounds");
      end else begin
         $display("FAIL box_corner_transform_bounds");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+design
design/bct_pkg.sv
design/bct_seq.sv
design/bct_mac.sv
design/bct_out.sv
design/box_corner_transform_bounds.sv
verif/tb.sv
